/* sv/msta_pkg.sv */
// ----------------------------------------------------------------------------
// msta_pkg - alarm table shared definitions
// Types, codes and constants of the multi-slot time alarm table.
// ----------------------------------------------------------------------------
package msta_pkg;

  // default number of alarm slots
  localparam int SLOTS_DEFAULT = 32;
  // most list entries one list request reports
  localparam int LIST_LIMIT    = 20;
  // most fired alarms one tick reports
  localparam int MAX_RESULTS   = 32;
  // result counter width, holds up to MAX_RESULTS
  localparam int COUNT_W       = $clog2(MAX_RESULTS + 1);
  // seen minute of a slot that has seen no tick yet
  localparam logic [7:0] SEEN_NONE = 8'hFF;
  // slot field value for no slot
  localparam logic [6:0] SLOT_NONE = 7'h7F;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_LIST   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_ENTRY = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_ACK,
    S_FLUSH
  } state_t;

  // one stored slot entry (active and fired bits live in flops)
  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] payload;
    logic [7:0]  seen;
  } entry_t;

  // verdict of the slot compare unit
  typedef struct packed {
    logic rearm;
    logic fire;
    logic fired_next;
  } match_t;

  // one result record
  typedef struct packed {
    kind_t       kind;
    logic        ok;
    logic [6:0]  slot;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] payload;
    logic        last;
  } res_t;

endpackage

/* sv/multi_slot_time_alarm_table_top.sv */
// ----------------------------------------------------------------------------
// multi_slot_time_alarm_table_top - alarm slot table with tick compare
// Add, remove, clear and list alarm slots; fire matching slots on a tick.
// ----------------------------------------------------------------------------
// One request at a time. Remove and clear go straight to the acknowledge
// state. Tick, list and add walk the slots one per cycle through the single
// read port of the slot ram and the shared compare unit, while the result side
// does not stall; a list stops after its twentieth entry. A disabled or
// invalid tick and an unknown action give no result. Results pass through an
// output register, so a new request is taken while the last result waits.
// Slot hour, minute, payload and seen minute sit in ram; the active and fired
// bits are flops, and reset clears them at once, so no clearing pass is run.
module multi_slot_time_alarm_table_top #(
  parameter int SLOTS = msta_pkg::SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,   // scheduling_enable
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,     // hour_value, minute_value, payload_index,
                                   // remove_target, clock_valid
  input  logic [2:0]  s_tuser,     // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,     // ok, slot_out, hour_out, minute_out, payload_out
  output logic [1:0]  m_tuser,     // result_kind
  output logic        m_tlast      // last_of_run
);

  import msta_pkg::*;

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENTRY_W = $bits(entry_t);

  state_t            state, state_next;
  logic              enable;
  logic [SLOTS-1:0]  active;
  logic [SLOTS-1:0]  fired;
  action_t           op;
  logic [4:0]        op_hour;
  logic [5:0]        op_minute;
  logic [15:0]       op_payload;
  logic [SLOT_W-1:0] idx;
  logic [COUNT_W-1:0] count;
  logic              ack_ok;
  logic [6:0]        ack_slot;
  logic              pend_valid;
  res_t              pend;
  res_t              out_res;
  logic              out_valid;

  // input fields
  logic [4:0]        in_hour;
  logic [5:0]        in_minute;
  logic [15:0]       in_payload;
  logic [7:0]        in_target;
  logic              in_clock_valid;
  logic              accept;
  logic              target_ok;
  logic [SLOT_W-1:0] target_idx;

  // scan signals
  entry_t            rd_entry;
  logic [ENTRY_W-1:0] ram_rdata;
  logic              ram_re, ram_we;
  logic [SLOT_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;
  match_t            mres;
  logic              cur_active, cur_fired;
  logic              is_tick, is_add, is_list;
  logic              room, found, out_free, stall, advance;
  logic              add_hit, last_idx, list_full;
  logic              out_load;
  res_t              load_res;
  res_t              new_res;

  assign in_hour        = s_tdata[4:0];
  assign in_minute      = s_tdata[10:5];
  assign in_payload     = s_tdata[26:11];
  assign in_target      = s_tdata[34:27];
  assign in_clock_valid = s_tdata[35];

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign target_ok  = !in_target[7] && ({1'b0, in_target[6:0]} < 8'(SLOTS));
  assign target_idx = in_target[SLOT_W-1:0];

  // current slot as seen by the scan
  assign rd_entry   = entry_t'(ram_rdata);
  assign cur_active = active[idx];
  assign cur_fired  = fired[idx];
  assign is_tick    = (op == ACT_TICK);
  assign is_add     = (op == ACT_ADD);
  assign is_list    = (op == ACT_LIST);
  assign room       = (count < COUNT_W'(MAX_RESULTS));
  assign last_idx   = (idx == SLOT_W'(SLOTS - 1));
  assign out_free   = !out_valid || m_tready;

  msta_match u_match (
    .entry  (rd_entry),
    .hour   (op_hour),
    .minute (op_minute),
    .fired  (cur_fired),
    .room   (room),
    .res    (mres)
  );

  // scan decisions
  assign found     = (state == S_EVAL) &&
                     ((is_tick && cur_active && mres.fire) || (is_list && cur_active));
  assign stall     = found && pend_valid && !out_free;
  assign advance   = (state == S_EVAL) && !stall;
  assign add_hit   = (state == S_EVAL) && is_add && !cur_active;
  assign list_full = is_list && found && (count == COUNT_W'(LIST_LIMIT - 1));

  always_comb begin
    new_res.kind    = is_tick ? KIND_FIRED : KIND_ENTRY;
    new_res.ok      = 1'b1;
    new_res.slot    = 7'(idx);
    new_res.hour    = rd_entry.hour;
    new_res.minute  = rd_entry.minute;
    new_res.payload = rd_entry.payload;
    new_res.last    = 1'b0;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (action_t'(s_tuser))
            ACT_TICK:   state_next = (enable && in_clock_valid) ? S_READ : S_IDLE;
            ACT_ADD:    state_next = S_READ;
            ACT_LIST:   state_next = S_READ;
            ACT_REMOVE: state_next = S_ACK;
            ACT_CLEAR:  state_next = S_ACK;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_READ: state_next = S_EVAL;
      S_EVAL: begin
        if (add_hit) begin
          state_next = S_ACK;
        end else if (advance) begin
          if (list_full) begin
            state_next = S_FLUSH;
          end else if (last_idx) begin
            state_next = is_add ? S_ACK : S_FLUSH;
          end
        end
      end
      S_ACK: begin
        if (out_free) state_next = S_IDLE;
      end
      S_FLUSH: begin
        if (pend_valid || is_list) begin
          if (out_free) state_next = S_IDLE;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ram access and result loading
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx;
    ram_we    = 1'b0;
    ram_wdata = ENTRY_W'({rd_entry.hour, rd_entry.minute, rd_entry.payload,
                          2'b00, op_minute});
    out_load  = 1'b0;
    load_res  = pend;
    case (state)
      S_READ: begin
        ram_re = 1'b1;
      end
      S_EVAL: begin
        ram_raddr = idx + SLOT_W'(1);
        ram_re    = advance && !last_idx && !list_full && !add_hit;
        if (add_hit) begin
          ram_we    = 1'b1;
          ram_wdata = ENTRY_W'({op_hour, op_minute, op_payload, SEEN_NONE});
        end else if (advance && is_tick && cur_active && mres.rearm) begin
          ram_we = 1'b1;
        end
        // hand the older pending result on when a new one arrives
        if (found && pend_valid && out_free) begin
          out_load      = 1'b1;
          load_res      = pend;
          load_res.last = 1'b0;
        end
      end
      S_ACK: begin
        out_load         = out_free;
        load_res.kind    = KIND_ACK;
        load_res.ok      = ack_ok;
        load_res.slot    = ack_slot;
        load_res.hour    = '0;
        load_res.minute  = '0;
        load_res.payload = '0;
        load_res.last    = 1'b1;
      end
      S_FLUSH: begin
        if (pend_valid) begin
          out_load      = out_free;
          load_res      = pend;
          load_res.last = 1'b1;
        end else if (is_list) begin
          out_load         = out_free;
          load_res.kind    = KIND_EMPTY;
          load_res.ok      = 1'b1;
          load_res.slot    = SLOT_NONE;
          load_res.hour    = '0;
          load_res.minute  = '0;
          load_res.payload = '0;
          load_res.last    = 1'b1;
        end
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  msta_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control and slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      enable     <= 1'b1;
      active     <= '0;
      fired      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      count      <= '0;
      idx        <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) enable <= cfg_wdata;

      // output register
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      // request decode
      if (accept) begin
        idx   <= '0;
        count <= '0;
        case (action_t'(s_tuser))
          ACT_REMOVE: begin
            if (target_ok) active[target_idx] <= 1'b0;
          end
          ACT_CLEAR: begin
            active <= '0;
          end
          default: begin
            active <= active;
          end
        endcase
      end

      // slot scan step
      if (add_hit) begin
        active[idx] <= 1'b1;
        fired[idx]  <= 1'b0;
      end else if (advance) begin
        idx <= idx + SLOT_W'(1);
        if (is_tick && cur_active) fired[idx] <= mres.fired_next;
        if (found) begin
          pend_valid <= 1'b1;
          count      <= count + COUNT_W'(1);
        end
      end

      if (state == S_FLUSH && out_load) pend_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= action_t'(s_tuser);
      op_hour    <= in_hour;
      op_minute  <= in_minute;
      op_payload <= in_payload;
      ack_ok     <= (action_t'(s_tuser) == ACT_REMOVE) ? target_ok : 1'b1;
      ack_slot   <= ((action_t'(s_tuser) == ACT_REMOVE) && target_ok) ? in_target[6:0]
                                                                      : SLOT_NONE;
    end
    if (add_hit) begin
      ack_ok   <= 1'b1;
      ack_slot <= 7'(idx);
    end else if (advance && last_idx && is_add) begin
      ack_ok   <= 1'b0;
      ack_slot <= SLOT_NONE;
    end
    if (advance && found) pend <= new_res;
    if (out_load) out_res <= load_res;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b00000, out_res.payload, out_res.minute, out_res.hour,
                     out_res.slot, out_res.ok};
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last;

endmodule

/* sv/msta_ram.sv */
// ----------------------------------------------------------------------------
// msta_ram - generic simple dual-port ram
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module msta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/msta_match.sv */
// ----------------------------------------------------------------------------
// msta_match - slot compare unit
// Shared by every slot of a tick scan: re-arm on a new minute, fire on match.
// ----------------------------------------------------------------------------
module msta_match (
  input  msta_pkg::entry_t entry,
  input  logic [4:0]       hour,
  input  logic [5:0]       minute,
  input  logic             fired,
  input  logic             room,
  output msta_pkg::match_t res
);

  import msta_pkg::*;

  logic fired_eff;

  // a new minute clears the fired flag before the time compare
  always_comb begin
    res.rearm      = (entry.seen != {2'b00, minute});
    fired_eff      = fired && !res.rearm;
    res.fire       = (entry.hour == hour) && (entry.minute == minute) && !fired_eff && room;
    res.fired_next = res.fire || fired_eff;
  end

endmodule

/* sv/msta_checker.sv */
// ----------------------------------------------------------------------------
// msta_props - port-level checks of the alarm table
// Watches the result stream of the top level; bound to it below.
// ----------------------------------------------------------------------------
module msta_props (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  import msta_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown after reset");

  // an acknowledge is always marked as the last result of its request
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_ACK) |-> m_tlast)
    else $error("acknowledge not marked last");

  // an empty list marker is last and names no slot
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_EMPTY) |-> m_tlast && (m_tdata[7:1] == SLOT_NONE))
    else $error("bad list empty result");

  // fired, entry and empty results always carry ok
  a_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != KIND_ACK) |-> m_tdata[0])
    else $error("non-acknowledge result without ok");

endmodule

bind multi_slot_time_alarm_table_top msta_props u_msta_props (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

/* tb/msta_checker.sv */
// ----------------------------------------------------------------------------
// msta_checker - alarm table result checker
// Watches the request, result and register ports of the alarm table, keeps
// its own slot table, predicts the results of each accepted request and
// compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module msta_checker #(
  parameter int SLOTS = msta_pkg::SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // hour_value, minute_value, payload_index,
                                 // remove_target, clock_valid
  input  logic [2:0]  s_tuser,   // action
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // ok, slot_out, hour_out, minute_out, payload_out
  input  logic [1:0]  m_tuser,   // result_kind
  input  logic        m_tlast,   // last_of_run
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import msta_pkg::*;

  // shadow slot table and enable register
  logic        sched_en;
  logic        slot_on     [SLOTS];
  logic [4:0]  alarm_hour  [SLOTS];
  logic [5:0]  alarm_min   [SLOTS];
  logic [15:0] alarm_pl    [SLOTS];
  logic        slot_done   [SLOTS];
  logic [7:0]  slot_seen   [SLOTS];

  res_t alarm_results_q[$];
  int   result_no;

  task automatic report_mismatch(input string msg);
    $display("%0t: result %0d: %s", $time, result_no, msg);
    fail_count++;
  endtask

  function automatic res_t make_res(kind_t k, logic ok, logic [6:0] sl, logic [4:0] h,
                                    logic [5:0] m, logic [15:0] p);
    res_t r;
    r.kind    = k;
    r.ok      = ok;
    r.slot    = sl;
    r.hour    = h;
    r.minute  = m;
    r.payload = p;
    r.last    = 1'b0;
    return r;
  endfunction

  // apply one request to the shadow table and queue the results it causes
  task automatic apply_alarm_request(input logic [2:0] act, input logic [39:0] d);
    logic [4:0]        hr;
    logic [5:0]        mn;
    logic [15:0]       pl;
    logic signed [7:0] tg;
    logic              vd;
    int                t;
    int                spare_idx;
    res_t              run[$];
    hr = d[4:0];
    mn = d[10:5];
    pl = d[26:11];
    tg = d[34:27];
    vd = d[35];
    case (act)
      ACT_TICK: begin
        if (sched_en && vd) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_on[i]) begin
              // a new minute re-arms the slot
              if (slot_seen[i] != {2'b00, mn}) begin
                slot_seen[i] = {2'b00, mn};
                slot_done[i] = 1'b0;
              end
              if (alarm_hour[i] == hr && alarm_min[i] == mn && !slot_done[i] &&
                  run.size() < MAX_RESULTS) begin
                run.push_back(make_res(KIND_FIRED, 1'b1, 7'(i), alarm_hour[i],
                                       alarm_min[i], alarm_pl[i]));
                slot_done[i] = 1'b1;
              end
            end
          end
        end
      end
      ACT_ADD: begin
        spare_idx = -1;
        for (int i = 0; i < SLOTS; i++)
          if (!slot_on[i] && spare_idx < 0) spare_idx = i;
        if (spare_idx >= 0) begin
          slot_on[spare_idx]    = 1'b1;
          alarm_hour[spare_idx] = hr;
          alarm_min[spare_idx]  = mn;
          alarm_pl[spare_idx]   = pl;
          slot_done[spare_idx]  = 1'b0;
          slot_seen[spare_idx]  = SEEN_NONE;
          run.push_back(make_res(KIND_ACK, 1'b1, 7'(spare_idx), '0, '0, '0));
        end else begin
          run.push_back(make_res(KIND_ACK, 1'b0, SLOT_NONE, '0, '0, '0));
        end
      end
      ACT_REMOVE: begin
        t = tg;
        if (t >= 0 && t < SLOTS) begin
          slot_on[t] = 1'b0;
          run.push_back(make_res(KIND_ACK, 1'b1, 7'(t), '0, '0, '0));
        end else begin
          run.push_back(make_res(KIND_ACK, 1'b0, SLOT_NONE, '0, '0, '0));
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) slot_on[i] = 1'b0;
        run.push_back(make_res(KIND_ACK, 1'b1, SLOT_NONE, '0, '0, '0));
      end
      ACT_LIST: begin
        for (int i = 0; i < SLOTS; i++)
          if (slot_on[i] && run.size() < LIST_LIMIT)
            run.push_back(make_res(KIND_ENTRY, 1'b1, 7'(i), alarm_hour[i],
                                   alarm_min[i], alarm_pl[i]));
        if (run.size() == 0)
          run.push_back(make_res(KIND_EMPTY, 1'b1, SLOT_NONE, '0, '0, '0));
      end
      default: begin
        // unknown actions are dropped
      end
    endcase
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[k]) alarm_results_q.push_back(run[k]);
  endtask

  // compare one accepted result with the oldest prediction
  task automatic check_result();
    res_t got;
    res_t want;
    got.kind    = kind_t'(m_tuser);
    got.ok      = m_tdata[0];
    got.slot    = m_tdata[7:1];
    got.hour    = m_tdata[12:8];
    got.minute  = m_tdata[18:13];
    got.payload = m_tdata[34:19];
    got.last    = m_tlast;
    if (alarm_results_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d slot %0d", got.kind, got.slot));
    end else begin
      want = alarm_results_q.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.ok !== want.ok)
        report_mismatch($sformatf("ok %0b, expected %0b", got.ok, want.ok));
      if (got.slot !== want.slot)
        report_mismatch($sformatf("slot %0h, expected %0h", got.slot, want.slot));
      if (got.hour !== want.hour)
        report_mismatch($sformatf("hour %0d, expected %0d", got.hour, want.hour));
      if (got.minute !== want.minute)
        report_mismatch($sformatf("minute %0d, expected %0d", got.minute, want.minute));
      if (got.payload !== want.payload)
        report_mismatch($sformatf("payload %0h, expected %0h", got.payload, want.payload));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
    end
    result_no++;
  endtask

  // sample all channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      sched_en   = 1'b1;
      fail_count = 0;
      result_no  = 0;
      alarm_results_q.delete();
      for (int i = 0; i < SLOTS; i++) begin
        slot_on[i]    = 1'b0;
        alarm_hour[i] = '0;
        alarm_min[i]  = '0;
        alarm_pl[i]   = '0;
        slot_done[i]  = 1'b0;
        slot_seen[i]  = SEEN_NONE;
      end
    end else begin
      if (cfg_we) sched_en = cfg_wdata;
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) apply_alarm_request(s_tuser, s_tdata);
    end
    pending = alarm_results_q.size();
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - alarm table testbench
// Drives directed and random requests into the alarm table with random gaps
// and result stalls, one long result stall, and enable register changes
// between phases. A checker module beside the table predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import msta_pkg::*;

  localparam int SLOTS         = 32;
  localparam int SETTLE_CYCLES = SLOTS + 8;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 300;
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;   // hour_value, minute_value, payload_index,
                                 // remove_target, clock_valid
  logic [2:0]  s_tuser   = '0;   // action
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;          // ok, slot_out, hour_out, minute_out, payload_out
  logic [1:0]  m_tuser;          // result_kind
  logic        m_tlast;          // last_of_run

  int fail_count;
  int pending;

  // sender and receiver pacing
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit long_hold = 1'b0;

  // small pools of times so ticks hit stored alarms
  logic [4:0] pool_hour[3];
  logic [5:0] pool_min[3];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_slot_time_alarm_table_top #(.SLOTS(SLOTS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  msta_checker #(.SLOTS(SLOTS)) alarm_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // offer one request and wait for it to be taken
  task automatic send_req(input logic [2:0] act, input logic [4:0] hr, input logic [5:0] mn,
                          input logic [15:0] pl, input logic [7:0] tg, input logic vd);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'b0000, vd, tg, pl, mn, hr};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering, wait for every predicted result, then let the table go idle
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    for (int c = 0; c < DRAIN_LIMIT && pending != 0; c++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_enable(input logic en);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one random request, mostly built from the time pools
  task automatic send_random(input int add_weight);
    int         r;
    int         p;
    logic [2:0] act;
    logic [4:0] hr;
    logic [5:0] mn;
    logic [7:0] tg;
    r = $urandom_range(0, 99);
    p = $urandom_range(0, 2);
    if ($urandom_range(0, 9) == 0) begin
      hr = 5'($urandom_range(0, 31));
      mn = 6'($urandom_range(0, 63));
    end else begin
      hr = pool_hour[p];
      mn = pool_min[$urandom_range(0, 2)];
    end
    if ($urandom_range(0, 4) == 0) tg = 8'($urandom_range(0, 255));
    else tg = 8'($urandom_range(0, SLOTS - 1));
    if (r < 35) act = ACT_TICK;
    else if (r < 35 + add_weight) act = ACT_ADD;
    else if (r < 47 + add_weight) act = ACT_REMOVE;
    else if (r < 49 + add_weight) act = ACT_CLEAR;
    else if (r < 97) act = ACT_LIST;
    else act = ACT_SPARE_FIRST + 3'($urandom_range(0, 2));
    send_req(act, hr, mn, 16'($urandom_range(0, 65535)), tg, $urandom_range(0, 9) != 0);
  endtask

  // result side: random stalls, steady stretches and one long hold-off
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 4);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // stimulus and verdict
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, field extremes and out of range times
    send_req(ACT_LIST,   5'd0,  6'd0,  16'h0000, 8'h00, 1'b1);
    send_req(ACT_ADD,    5'd0,  6'd0,  16'h0000, 8'h00, 1'b0);
    send_req(ACT_ADD,    5'd23, 6'd59, 16'hFFFF, 8'hFF, 1'b1);
    send_req(ACT_ADD,    5'd31, 6'd63, 16'h5A5A, 8'h7F, 1'b0);
    send_req(ACT_LIST,   5'd31, 6'd63, 16'hFFFF, 8'hFF, 1'b1);
    // fire once per minute, re-arm on a minute change
    send_req(ACT_TICK,   5'd23, 6'd59, 16'h0000, 8'h00, 1'b1);
    send_req(ACT_TICK,   5'd23, 6'd59, 16'h0000, 8'h00, 1'b1);
    send_req(ACT_TICK,   5'd23, 6'd58, 16'h0000, 8'h00, 1'b1);
    send_req(ACT_TICK,   5'd23, 6'd59, 16'h0000, 8'h00, 1'b1);
    // invalid clock is ignored
    send_req(ACT_TICK,   5'd0,  6'd0,  16'h0000, 8'h00, 1'b0);
    send_req(ACT_TICK,   5'd0,  6'd0,  16'h0000, 8'h00, 1'b1);
    send_req(ACT_TICK,   5'd31, 6'd63, 16'h0000, 8'h00, 1'b1);
    // remove targets out of range, on an inactive slot and on a live slot
    send_req(ACT_REMOVE, 5'd0,  6'd0,  16'h0000, 8'h7F, 1'b0);
    send_req(ACT_REMOVE, 5'd0,  6'd0,  16'h0000, 8'h80, 1'b0);
    send_req(ACT_REMOVE, 5'd0,  6'd0,  16'h0000, 8'hFF, 1'b0);
    send_req(ACT_REMOVE, 5'd0,  6'd0,  16'h0000, 8'(SLOTS), 1'b0);
    send_req(ACT_REMOVE, 5'd0,  6'd0,  16'h0000, 8'(SLOTS - 1), 1'b0);
    send_req(ACT_REMOVE, 5'd0,  6'd0,  16'h0000, 8'h00, 1'b0);
    // unknown actions give nothing
    send_req(ACT_SPARE_FIRST,        5'd1, 6'd1, 16'h1234, 8'h01, 1'b1);
    send_req(ACT_SPARE_FIRST + 3'd1, 5'd1, 6'd1, 16'h1234, 8'h01, 1'b1);
    send_req(ACT_SPARE_FIRST + 3'd2, 5'd1, 6'd1, 16'h1234, 8'h01, 1'b1);
    // freed slot is reused, then clear empties the table
    send_req(ACT_ADD,    5'd12, 6'd0,  16'hA5A5, 8'h00, 1'b1);
    send_req(ACT_LIST,   5'd0,  6'd0,  16'h0000, 8'h00, 1'b1);
    send_req(ACT_CLEAR,  5'd0,  6'd0,  16'h0000, 8'h00, 1'b1);
    send_req(ACT_LIST,   5'd0,  6'd0,  16'h0000, 8'h00, 1'b1);

    // full table: failed add, every slot firing on one tick, list cut short
    for (int i = 0; i <= SLOTS; i++)
      send_req(ACT_ADD, 5'd12, 6'd30, 16'($urandom_range(0, 65535)), 8'h00, 1'b1);
    send_req(ACT_TICK, 5'd12, 6'd30, 16'h0000, 8'h00, 1'b1);
    send_req(ACT_LIST, 5'd0,  6'd0,  16'h0000, 8'h00, 1'b1);

    // disabled ticks neither fire nor re-arm
    set_enable(1'b0);
    send_req(ACT_TICK, 5'd12, 6'd31, 16'h0000, 8'h00, 1'b1);
    send_req(ACT_TICK, 5'd12, 6'd30, 16'h0000, 8'h00, 1'b1);
    set_enable(1'b1);
    send_req(ACT_TICK, 5'd12, 6'd30, 16'h0000, 8'h00, 1'b1);
    send_req(ACT_TICK, 5'd12, 6'd31, 16'h0000, 8'h00, 1'b1);
    send_req(ACT_TICK, 5'd12, 6'd30, 16'h0000, 8'h00, 1'b1);
    send_req(ACT_CLEAR, 5'd0, 6'd0, 16'h0000, 8'h00, 1'b1);

    // random phases with varied pacing, enable and table load
    for (int p = 0; p < 5; p++) begin
      set_enable(p != 1 && p != 3);
      for (int k = 0; k < 3; k++) begin
        pool_hour[k] = 5'($urandom_range(0, 23));
        pool_min[k]  = 6'($urandom_range(0, 59));
      end
      tx_steady = (p == 1);
      rx_steady = (p == 3);
      if (p == 2) long_hold = 1'b1;
      repeat (100) send_random(p == 4 ? 45 : 25);
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* multi_slot_time_alarm_table_top.f */
sv/msta_pkg.sv
sv/msta_ram.sv
sv/msta_match.sv
sv/multi_slot_time_alarm_table_top.sv
sv/msta_checker.sv
tb/msta_checker.sv
tb/tb_top.sv
